/* rtl/core/vadn_pkg.sv */
// Package for the vector affine unit: payload structs, register indexes,
// sequencer states and constants. No dependencies.
package vadn_pkg;

	localparam int MaxLen = 1024;
	localparam int AddrW = $clog2(MaxLen);
	localparam int CountW = AddrW + 1;

	localparam logic [2:0] REG_COEF_A = 3'd0;
	localparam logic [2:0] REG_COEF_B = 3'd1;
	localparam logic [2:0] REG_COEF_C = 3'd2;
	localparam logic [2:0] REG_COEF_D = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_DOT = 2'd1;
	localparam logic [1:0] MODE_REV = 2'd2;
	localparam logic [1:0] MODE_NORM = 2'd3;

	localparam logic signed [63:0] S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64Min = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [31:0] x1_value;
		logic signed [31:0] x2_value;
		logic is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] y_value;
		logic final_flag;
		logic signed [63:0] reduction;
		logic length_error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P0,
		ST_PA_HI,
		ST_PA_LO,
		ST_PB,
		ST_PC,
		ST_Y,
		ST_YSQ,
		ST_ACC,
		ST_REV_RD,
		ST_REV_MUL,
		ST_REV_ADD,
		ST_SQ_GO,
		ST_SQRT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [32:0] a;
		logic signed [32:0] b;
	} mul_op_t;

	function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(S64Max)) begin
			return S64Max;
		end else if (s < 65'(S64Min)) begin
			return S64Min;
		end
		return s[63:0];
	endfunction

endpackage

/* rtl/core/vector_affine_dot_norm.sv */
// Vector affine map with an optional reduction on the final element.
// An element runs through the sequencer states from acceptance to the done strobe; the final
// element then also runs the reversed product (n stored pairs, one memory
// read and one shared multiply each) or the norm's square root.
// Handshake: busy stays high until the strobe cycle, in which the next transaction
// may be accepted. The receiver cannot stall. Reset clears coefficients, mode, sum, count.
module vector_affine_dot_norm import vadn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input in_item_t in_item,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic done,
	output out_item_t out_item
);

	logic signed [31:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic [1:0] mode_q;
	logic signed [31:0] first_mem [MaxLen];
	logic signed [31:0] second_mem [MaxLen];
	logic signed [31:0] rd1_q, rd2_q;
	state_t state_q, state_d;
	in_item_t item_q;
	logic signed [63:0] sum_q, red_q;
	logic signed [65:0] p_q, t_q;
	logic [CountW-1:0] count_q, idx_q;
	logic ovf_q;
	logic signed [31:0] y_q;
	mul_op_t op;
	logic signed [65:0] prod_q;
	logic sq_start, sq_done;
	logic [39:0] root_q;
	logic [CountW-1:0] ridx;

	vadn_mul u_mul (.clk(clk), .op(op), .prod_q(prod_q));
	vadn_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start),
		.s(sum_q[63] ? 63'd0 : sum_q[62:0]), .done(sq_done), .root_q(root_q));

	assign busy = (state_q != ST_IDLE);
	assign ridx = count_q - CountW'(1) - idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			coef_d_q <= '0;
			mode_q <= MODE_NONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_A: coef_a_q <= cfg_data;
				REG_COEF_B: coef_b_q <= cfg_data;
				REG_COEF_C: coef_c_q <= cfg_data;
				REG_COEF_D: coef_d_q <= cfg_data;
				REG_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		op.a = {item_q.x1_value[31], item_q.x1_value};
		op.b = {item_q.x2_value[31], item_q.x2_value};
		sq_start = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_P0;
			ST_P0: state_d = ST_PA_HI;
			ST_PA_HI: begin
				op.a = {coef_a_q[31], coef_a_q};
				op.b = {prod_q[63], prod_q[63:32]};
				state_d = ST_PA_LO;
			end
			ST_PA_LO: begin
				op.a = {coef_a_q[31], coef_a_q};
				op.b = {1'b0, p_q[31:0]};
				state_d = ST_PB;
			end
			ST_PB: begin
				op.a = {coef_b_q[31], coef_b_q};
				op.b = {item_q.x1_value[31], item_q.x1_value};
				state_d = ST_PC;
			end
			ST_PC: begin
				op.a = {coef_c_q[31], coef_c_q};
				op.b = {item_q.x2_value[31], item_q.x2_value};
				state_d = ST_Y;
			end
			ST_Y: begin
				op.a = {y_q[31], y_q};
				op.b = {y_q[31], y_q};
				state_d = ST_YSQ;
			end
			ST_YSQ: begin
				op.a = {y_q[31], y_q};
				op.b = {y_q[31], y_q};
				state_d = ST_ACC;
			end
			ST_ACC: begin
				op.a = {y_q[31], y_q};
				op.b = {y_q[31], y_q};
				if (!item_q.is_last || ovf_q || mode_q == MODE_NONE
					|| mode_q == MODE_DOT) begin
					state_d = ST_DONE;
				end else if (mode_q == MODE_NORM) begin
					state_d = ST_SQ_GO;
				end else if (count_q == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_REV_RD;
				end
			end
			ST_REV_RD: state_d = ST_REV_MUL;
			ST_REV_MUL: begin
				op.a = {rd1_q[31], rd1_q};
				op.b = {rd2_q[31], rd2_q};
				state_d = ST_REV_ADD;
			end
			ST_REV_ADD: begin
				state_d = (idx_q == count_q) ? ST_DONE : ST_REV_RD;
			end
			ST_SQ_GO: begin
				sq_start = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: if (sq_done) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == ST_DONE);
			if (state_q == ST_P0) begin
				if (count_q < CountW'(MaxLen)) begin
					count_q <= count_q + CountW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_ACC && mode_q == MODE_DOT) begin
				sum_q <= sat_add64(sum_q, $signed(p_q[63:0]) >>> 16);
			end else if (state_q == ST_ACC && mode_q == MODE_NORM) begin
				sum_q <= sat_add64(sum_q, $signed(prod_q[63:0]) >>> 16);
			end
			if (state_q == ST_DONE && item_q.is_last) begin
				sum_q <= '0;
				count_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			item_q <= in_item;
			if (count_q < CountW'(MaxLen)) begin
				first_mem[count_q[AddrW-1:0]] <= in_item.x1_value;
				second_mem[count_q[AddrW-1:0]] <= in_item.x2_value;
			end
		end
		rd1_q <= first_mem[idx_q[AddrW-1:0]];
		rd2_q <= second_mem[ridx[AddrW-1:0]];
		case (state_q)
			ST_P0: begin
				t_q <= 66'(coef_d_q);
				idx_q <= '0;
				red_q <= '0;
			end
			ST_PA_HI: p_q <= prod_q;
			ST_PA_LO: t_q <= t_q + prod_q;
			ST_PB: t_q <= t_q + (prod_q >>> 32);
			ST_PC: t_q <= t_q + (prod_q >>> 16);
			ST_Y: begin
				if (t_q + (prod_q >>> 16) > 66'sd2147483647) begin
					y_q <= 32'sh7FFF_FFFF;
				end else if (t_q + (prod_q >>> 16) < -66'sd2147483648) begin
					y_q <= 32'sh8000_0000;
				end else begin
					y_q <= 32'(t_q + (prod_q >>> 16));
				end
			end
			ST_REV_RD: idx_q <= idx_q + CountW'(1);
			ST_REV_ADD: red_q <= sat_add64(red_q, $signed(prod_q[63:0]) >>> 16);
			default: ;
		endcase
		if (state_q == ST_DONE) begin
			out_item.y_value <= y_q;
			out_item.final_flag <= item_q.is_last;
			out_item.length_error <= ovf_q;
			if (item_q.is_last && !ovf_q) begin
				case (mode_q)
					MODE_DOT: out_item.reduction <= sum_q;
					MODE_REV: out_item.reduction <= red_q;
					MODE_NORM: out_item.reduction <= {24'd0, root_q};
					default: out_item.reduction <= '0;
				endcase
			end else begin
				out_item.reduction <= '0;
			end
		end
	end

	// The product register holds x1*x2 from the end of ST_P0 through ST_PA_HI.
	// In ST_PA_HI, prod_q is x1*x2 and is stored in p_q for later use.

endmodule

/* rtl/core/vadn_mul.sv */
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on vadn_pkg.
module vadn_mul import vadn_pkg::*; (
	input logic clk,
	input mul_op_t op,
	output logic signed [65:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op.a * op.b;
	end

endmodule

/* rtl/core/vadn_sqrt.sv */
// Iterative square root, one result bit per cycle: floor(sqrt(s * 2^16)).
// Depends on vadn_pkg.
module vadn_sqrt import vadn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [62:0] s,
	output logic done,
	output logic [39:0] root_q
);

	logic [79:0] rad_q;
	logic [41:0] rem_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [41:0] rem_sh;
	logic [41:0] trial;

	assign rem_sh = {rem_q[39:0], rad_q[79:78]};
	assign trial = {root_q, 2'b01};
	assign done = busy_q && (cnt_q == 7'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 7'd40;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= {1'b0, s, 16'd0};
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q && cnt_q != 7'd0) begin
			rad_q <= {rad_q[77:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[38:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[38:0], 1'b0};
			end
		end
	end

endmodule

/* tb/tb_vector_affine_dot_norm.sv */
// Self-checking testbench for vector_affine_dot_norm: directed and random element pairs
// are checked against an in-bench predictor of the affine map and its reductions.
// Depends on vadn_pkg and the vector_affine_dot_norm RTL.
`timescale 1ns / 1ps

module tb_vector_affine_dot_norm;
	import vadn_pkg::*;

	typedef enum logic {K_ITEM, K_CFG} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		in_item_t item;
		int gap_pct;
		logic [2:0] index;
		logic [31:0] data;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t in_item = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_COEF_A;
	logic [31:0] cfg_data = '0;
	logic done;
	out_item_t out_item;

	pending_t pending_q[$];
	out_item_t expected_q[$];
	int errors = 0;
	int items_sent = 0;
	int vectors_closed = 0;
	int results_seen = 0;
	int quiet = 0;
	int gap_pct = 0;

	// Predictor state.
	logic signed [31:0] k_a, k_b, k_c, k_d;
	logic [1:0] red_mode;
	logic signed [31:0] first_mem[MaxLen];
	logic signed [31:0] second_mem[MaxLen];
	logic signed [63:0] acc_sum;
	int elem_cnt;
	logic too_long;

	vector_affine_dot_norm u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.out_item(out_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic signed [63:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p >>> 16;
	endfunction

	function automatic logic signed [63:0] add_clamp(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] affine_y(logic signed [31:0] x1,
		logic signed [31:0] x2);
		logic signed [127:0] wa, w1, w2, t;
		wa = k_a;
		w1 = x1;
		w2 = x2;
		t = (wa * w1 * w2) >>> 32;
		t = t + q_mul(k_b, x1) + q_mul(k_c, x2) + k_d;
		if (t > 128'sh7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (t < -128'sh8000_0000) begin
			return 32'sh8000_0000;
		end
		return t[31:0];
	endfunction

	function automatic logic signed [63:0] root_q(logic signed [63:0] s);
		logic [127:0] v, cand;
		logic [63:0] r;
		v = {64'd0, s} << 16;
		r = '0;
		for (int k = 39; k >= 0; k--) begin
			cand = {64'd0, r | (64'd1 << k)};
			if (cand * cand <= v) begin
				r = cand[63:0];
			end
		end
		return r;
	endfunction

	function automatic out_item_t predict_result(in_item_t it);
		out_item_t r;
		logic signed [31:0] y;
		logic signed [63:0] red;
		y = affine_y(it.x1_value, it.x2_value);
		red = '0;
		if (elem_cnt < MaxLen) begin
			first_mem[elem_cnt] = it.x1_value;
			second_mem[elem_cnt] = it.x2_value;
			elem_cnt++;
		end else begin
			too_long = 1'b1;
		end
		if (red_mode == MODE_DOT) begin
			acc_sum = add_clamp(acc_sum, q_mul(it.x1_value, it.x2_value));
		end else if (red_mode == MODE_NORM) begin
			acc_sum = add_clamp(acc_sum, q_mul(y, y));
		end
		r.y_value = y;
		r.final_flag = it.is_last;
		r.length_error = too_long;
		if (it.is_last) begin
			if (!too_long) begin
				case (red_mode)
					MODE_DOT: begin
						red = acc_sum;
					end
					MODE_NORM: begin
						red = root_q(acc_sum < 0 ? 64'sd0 : acc_sum);
					end
					MODE_REV: begin
						for (int i = 0; i < elem_cnt; i++) begin
							red = add_clamp(red, q_mul(first_mem[i],
								second_mem[elem_cnt - 1 - i]));
						end
					end
					default: begin
						red = '0;
					end
				endcase
			end
			acc_sum = '0;
			elem_cnt = 0;
			too_long = 1'b0;
		end
		r.reduction = red;
		return r;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [31:0] d);
		case (idx)
			REG_COEF_A: k_a = d;
			REG_COEF_B: k_b = d;
			REG_COEF_C: k_c = d;
			REG_COEF_D: k_d = d;
			REG_MODE: red_mode = d[1:0];
			default: ;
		endcase
	endfunction

	// Transaction driver; the predictor advances on each accepted item.
	always @(posedge clk) begin
		logic acc, nx_start, nx_we;
		in_item_t nx_item;
		logic [2:0] nx_idx;
		logic [31:0] nx_data;
		if (arst_n) begin
			acc = start && !busy;
			if (acc) begin
				expected_q.push_back(predict_result(in_item));
				items_sent++;
				if (in_item.is_last) begin
					vectors_closed++;
				end
			end
			quiet = (!busy && !acc && expected_q.size() == 0) ? quiet + 1 : 0;
			nx_start = start && !acc;
			nx_we = 1'b0;
			nx_item = in_item;
			nx_idx = cfg_index;
			nx_data = cfg_data;
			if (!nx_start && pending_q.size() > 0) begin
				if (pending_q[0].kind == K_CFG) begin
					if (quiet >= 3 && !start) begin
						apply_reg(pending_q[0].index, pending_q[0].data);
						nx_we = 1'b1;
						nx_idx = pending_q[0].index;
						nx_data = pending_q[0].data;
						void'(pending_q.pop_front());
					end
				end else if ($urandom_range(0, 99) >= pending_q[0].gap_pct) begin
					nx_start = 1'b1;
					nx_item = pending_q[0].item;
					void'(pending_q.pop_front());
				end
			end
			start <= nx_start;
			cfg_we <= nx_we;
			in_item <= nx_item;
			cfg_index <= nx_idx;
			cfg_data <= nx_data;
		end
	end

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && done) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_item);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_item.y_value !== e.y_value) begin
					$display("%0t: y_value expected %h actual %h", $time, e.y_value,
						out_item.y_value);
					errors++;
				end
				if (out_item.final_flag !== e.final_flag) begin
					$display("%0t: final_flag expected %b actual %b", $time,
						e.final_flag, out_item.final_flag);
					errors++;
				end
				if (out_item.reduction !== e.reduction) begin
					$display("%0t: reduction expected %h actual %h", $time,
						e.reduction, out_item.reduction);
					errors++;
				end
				if (out_item.length_error !== e.length_error) begin
					$display("%0t: length_error expected %b actual %b", $time,
						e.length_error, out_item.length_error);
					errors++;
				end
			end
		end
	end

	function automatic void add_item(logic signed [31:0] x1, logic signed [31:0] x2,
		logic last);
		pending_t p;
		p.kind = K_ITEM;
		p.item.x1_value = x1;
		p.item.x2_value = x2;
		p.item.is_last = last;
		p.gap_pct = gap_pct;
		p.index = REG_COEF_A;
		p.data = '0;
		pending_q.push_back(p);
	endfunction

	function automatic void add_cfg(logic [2:0] idx, logic [31:0] d);
		pending_t p;
		p.kind = K_CFG;
		p.item = '0;
		p.gap_pct = 0;
		p.index = idx;
		p.data = d;
		pending_q.push_back(p);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom;
			default: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
		endcase
	endfunction

	function automatic void add_vector(int len);
		for (int i = 0; i < len; i++) begin
			add_item(pick_value(), pick_value(), i == len - 1);
		end
	endfunction

	initial begin
		int phase_pct[3];
		k_a = '0;
		k_b = '0;
		k_c = '0;
		k_d = '0;
		red_mode = MODE_NONE;
		acc_sum = '0;
		elem_cnt = 0;
		too_long = 1'b0;
		phase_pct = '{34, 0, 0};

		add_cfg(REG_COEF_A, 32'h0001_0000);
		add_cfg(REG_COEF_B, 32'h0000_8000);
		add_cfg(REG_COEF_C, 32'hFFFF_0000);
		add_cfg(REG_COEF_D, 32'd5);
		add_cfg(REG_MODE, MODE_DOT);
		add_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		add_item(32'sh8000_0000, 32'sh8000_0000, 1'b0);
		add_item(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		add_item(32'sh0, 32'sh0, 1'b0);
		add_item(-32'sd1, 32'sd1, 1'b1);
		add_cfg(REG_MODE, MODE_REV);
		add_vector(3);
		add_cfg(REG_COEF_A, 32'h7FFF_FFFF);
		add_cfg(REG_MODE, MODE_NORM);
		add_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		add_item(32'sd1, 32'sd1, 1'b1);
		add_cfg(REG_MODE, MODE_NONE);
		add_item(32'sh1234_5678, -32'sh0765_4321, 1'b1);
		// The mode changes part-way through this vector.
		add_cfg(REG_MODE, MODE_DOT);
		add_vector(2);
		void'(pending_q.pop_back());
		add_item(32'sh0003_0000, 32'sh0002_0000, 1'b0);
		add_cfg(REG_MODE, MODE_NORM);
		add_item(32'sh0001_8000, -32'sh0004_0000, 1'b1);
		add_cfg(REG_COEF_A, 32'h8000_0000);
		add_cfg(REG_COEF_B, 32'h8000_0000);
		add_cfg(REG_COEF_C, 32'h8000_0000);
		add_cfg(REG_COEF_D, 32'h8000_0000);
		add_item(32'sh8000_0000, 32'sh8000_0000, 1'b1);
		add_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);

		phase_pct = '{34, 70, 0};
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = phase_pct[ph];
			for (int s = 0; s < 9; s++) begin
				add_cfg(REG_COEF_A, pick_coef());
				add_cfg(REG_COEF_B, pick_coef());
				add_cfg(REG_COEF_C, pick_coef());
				add_cfg(REG_COEF_D, pick_coef());
				add_cfg(REG_MODE, $urandom_range(0, 3));
				for (int v = 0; v < 8; v++) begin
					if ($urandom_range(0, 7) == 0) begin
						add_cfg(REG_MODE, $urandom_range(0, 3));
					end
					add_vector($urandom_range(1, 6));
				end
			end
			if ((ph % 3) == 2) begin
				gap_pct = 0;
			end
		end
		// A longer vector walked backwards through the stores.
		add_cfg(REG_MODE, MODE_REV);
		add_vector(80);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		do begin
			@(posedge clk);
		end while (pending_q.size() != 0 || start || expected_q.size() != 0);
		repeat (40) @(posedge clk);
		$display("Covered %0d transactions in %0d vectors, %0d results checked,",
			items_sent, vectors_closed, results_seen);
		$display("all four reduction modes, saturation and a long reversed walk.");
		if (errors == 0) begin
			$display("tb_vector_affine_dot_norm: done, clean");
		end else begin
			$display("tb_vector_affine_dot_norm: done, errors");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timed out with %0d results outstanding.", expected_q.size());
		$display("tb_vector_affine_dot_norm: done, errors");
		$finish;
	end

endmodule
